// ----- src/mfu_pkg.sv -----
// ----------------------------------------------------------------------------
// mfu_pkg
// Shared constants and types of the most-frequently-used page replacement
// block: table sizes, field widths and the structs between the modules.
// ----------------------------------------------------------------------------
package mfu_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 8;
    localparam int PAGE_SPACE = 1 << PAGE_BITS;
    localparam int FRAME_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W     = $clog2(FRAMES + 1);
    localparam int CFG_W      = 4;
    localparam int CMP_W      = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int CNT_W      = 16;
    localparam int TIME_W     = 32;
    localparam int PAGE_FW    = 8;
    localparam int FRAME_FW   = 3;
    localparam int OUT_W      = 16;

    localparam logic [CFG_W-1:0]  CFG_RST  = CFG_W'(8);
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [FRAME_W-1:0]   t_frame_idx;
    typedef logic [FILL_W-1:0]    t_fill;

    // update request from the sequencer to the frame table
    typedef struct packed {
        logic  commit;
        t_cnt  count;
        t_time now;
        t_fill limit;
    } t_upd;

    // decision of the frame table for the item under update
    typedef struct packed {
        logic       hit;
        t_frame_idx frame;
        logic       replaced;
        t_page      evicted;
    } t_res;

endpackage

// ----- src/mfu_count_store.sv -----
// ----------------------------------------------------------------------------
// mfu_count_store
// Per-page reference counters in a synchronous memory. A read in one cycle
// gives the saturated incremented count in the next, which is then written
// back to the same entry. Valid bits make never-written entries read as zero.
// ----------------------------------------------------------------------------
module mfu_count_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  mfu_pkg::t_page     i_rd_page,
    input  logic               i_wr_en,
    output mfu_pkg::t_cnt      o_cnt_new
);

    mfu_pkg::t_cnt                   r_mem [mfu_pkg::PAGE_SPACE];
    logic [mfu_pkg::PAGE_SPACE-1:0]  r_vld;
    mfu_pkg::t_cnt                   r_q;
    logic                            r_qv;
    mfu_pkg::t_page                  r_addr;
    mfu_pkg::t_cnt                   n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_addr] <= n_cnt;
        end
        if (i_rd_en) begin
            r_q    <= r_mem[i_rd_page];
            r_qv   <= r_vld[i_rd_page];
            r_addr <= i_rd_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    // never-written entry counts as zero, count saturates
    always_comb begin
        if (!r_qv) begin
            n_cnt = mfu_pkg::CNT_W'(1);
        end else if (r_q == mfu_pkg::CNT_MAX) begin
            n_cnt = r_q;
        end else begin
            n_cnt = r_q + mfu_pkg::CNT_W'(1);
        end
    end

    assign o_cnt_new = n_cnt;

endmodule

// ----- src/mfu_frame_table.sv -----
// ----------------------------------------------------------------------------
// mfu_frame_table
// Resident page, last-use time and a mirror of the reference count for each
// frame. The lookup cycle registers the hit search and the victim choice;
// the update cycle decides hit, fill or eviction and writes the frame.
// ----------------------------------------------------------------------------
module mfu_frame_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_lookup,
    input  mfu_pkg::t_page     i_page,
    input  mfu_pkg::t_upd      i_upd,
    output mfu_pkg::t_res      o_res
);

    mfu_pkg::t_page      r_pg  [mfu_pkg::FRAMES];
    mfu_pkg::t_time      r_use [mfu_pkg::FRAMES];
    mfu_pkg::t_cnt       r_cnt [mfu_pkg::FRAMES];
    mfu_pkg::t_fill      r_filled;
    logic                r_hit;
    mfu_pkg::t_frame_idx r_hit_idx;
    mfu_pkg::t_frame_idx r_victim;
    mfu_pkg::t_page      r_page;

    logic                       n_hit;
    mfu_pkg::t_frame_idx        n_hit_idx;
    mfu_pkg::t_frame_idx        n_victim;
    logic [mfu_pkg::FRAMES-1:0] cand;
    logic                       fill;
    mfu_pkg::t_res              res;

    // lowest filled frame that holds the page
    always_comb begin
        n_hit     = 1'b0;
        n_hit_idx = '0;
        for (int i = mfu_pkg::FRAMES - 1; i >= 0; i--) begin
            if (mfu_pkg::FILL_W'(i) < r_filled && r_pg[i] == i_page) begin
                n_hit     = 1'b1;
                n_hit_idx = mfu_pkg::FRAME_W'(i);
            end
        end
    end

    // frame i survives if no other filled frame beats it:
    // higher count, then older use, then lower index
    always_comb begin
        for (int i = 0; i < mfu_pkg::FRAMES; i++) begin
            cand[i] = (mfu_pkg::FILL_W'(i) < r_filled);
            for (int j = 0; j < mfu_pkg::FRAMES; j++) begin
                if (j != i && mfu_pkg::FILL_W'(j) < r_filled &&
                    (r_cnt[j] > r_cnt[i] ||
                     (r_cnt[j] == r_cnt[i] &&
                      (r_use[j] < r_use[i] || (r_use[j] == r_use[i] && j < i))))) begin
                    cand[i] = 1'b0;
                end
            end
        end
        n_victim = '0;
        for (int i = mfu_pkg::FRAMES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                n_victim = mfu_pkg::FRAME_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lookup) begin
            r_hit     <= n_hit;
            r_hit_idx <= n_hit_idx;
            r_victim  <= n_victim;
            r_page    <= i_page;
        end
    end

    always_comb begin
        res  = '0;
        fill = 1'b0;
        if (r_hit) begin
            res.hit   = 1'b1;
            res.frame = r_hit_idx;
        end else if (r_filled >= i_upd.limit) begin
            res.replaced = 1'b1;
            res.frame    = r_victim;
            res.evicted  = r_pg[r_victim];
        end else begin
            fill      = 1'b1;
            res.frame = r_filled[mfu_pkg::FRAME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.commit) begin
            r_pg[res.frame]  <= r_page;
            r_use[res.frame] <= i_upd.now;
            r_cnt[res.frame] <= i_upd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (i_upd.commit && fill) begin
            r_filled <= r_filled + mfu_pkg::FILL_W'(1);
        end
    end

    assign o_res = res;

endmodule

// ----- src/mfu_page_replacement.sv -----
// ----------------------------------------------------------------------------
// mfu_page_replacement
// Most-frequently-used page replacement over a small set of page frames.
// ----------------------------------------------------------------------------
// Input stream: one page reference per item, page in i_s_tdata[7:0].
// Output stream: one result per reference: hit, frame, replaced and the
// evicted page (zero when nothing was evicted).
// Config: i_cfg_we writes i_cfg_wdata into the frame limit; 0 acts as 1 and
// values above the frame count act as the frame count. Write only when idle.
// Timing: an item is accepted, the count memory is read and the frame table
// searched in ST_READ; the count is written back, the frame updated and the
// result registered in ST_UPDATE. No new item is taken until the update of
// the last one completes, set by the read-modify-write of the count memory.
// Reset: counters read as zero, no frames resident, limit back to 8, time 0.
// Stall: a held result blocks the update cycle of the next item, which then
// waits with its lookup captured; no item is taken until it completes.
// ----------------------------------------------------------------------------
module mfu_page_replacement (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [mfu_pkg::PAGE_FW-1:0]      i_s_tdata,  // page
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [mfu_pkg::OUT_W-1:0]        o_m_tdata,  // hit, frame[2:0], replaced,
                                                         // evicted_page[7:0], zero pad
    input  logic                             i_cfg_we,
    input  logic [mfu_pkg::CFG_W-1:0]        i_cfg_wdata
);

    typedef enum logic [1:0] {
        ST_READ   = 2'b01,
        ST_UPDATE = 2'b10
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [mfu_pkg::CFG_W-1:0]    r_cfg;
    mfu_pkg::t_time               r_time;
    logic                         r_m_vld;
    logic [mfu_pkg::OUT_W-1:0]    r_m_data;

    logic                         accept;
    logic                         done;
    mfu_pkg::t_page               page;
    mfu_pkg::t_cnt                cnt_new;
    mfu_pkg::t_fill               lim;
    logic [mfu_pkg::CMP_W-1:0]    cfg_x;
    mfu_pkg::t_upd                upd;
    mfu_pkg::t_res                res;

    assign o_s_tready = (r_state == ST_READ);
    assign accept     = i_s_tvalid && o_s_tready;
    assign done       = (r_state == ST_UPDATE) && (!r_m_vld || i_m_tready);
    assign page       = i_s_tdata[mfu_pkg::PAGE_BITS-1:0];

    always_comb begin
        cfg_x = mfu_pkg::CMP_W'(r_cfg);
        if (cfg_x == '0) begin
            lim = mfu_pkg::FILL_W'(1);
        end else if (cfg_x > mfu_pkg::CMP_W'(mfu_pkg::FRAMES)) begin
            lim = mfu_pkg::FILL_W'(mfu_pkg::FRAMES);
        end else begin
            lim = mfu_pkg::FILL_W'(cfg_x);
        end
    end

    always_comb begin
        case (r_state)
            ST_READ:   n_state = accept ? ST_UPDATE : ST_READ;
            ST_UPDATE: n_state = done ? ST_READ : ST_UPDATE;
            default:   n_state = ST_READ;
        endcase
    end

    assign upd.commit = done;
    assign upd.count  = cnt_new;
    assign upd.now    = r_time;
    assign upd.limit  = lim;

    mfu_count_store u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_page (page),
        .i_wr_en   (done),
        .o_cnt_new (cnt_new)
    );

    mfu_frame_table u_frames (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (accept),
        .i_page   (page),
        .i_upd    (upd),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READ;
            r_cfg   <= mfu_pkg::CFG_RST;
            r_time  <= '0;
            r_m_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (done && r_time != mfu_pkg::TIME_MAX) begin
                r_time <= r_time + mfu_pkg::TIME_W'(1);
            end
            if (done) begin
                r_m_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_m_data <= {3'b000,
                         mfu_pkg::PAGE_FW'(res.evicted),
                         res.replaced,
                         mfu_pkg::FRAME_FW'(res.frame),
                         res.hit};
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = r_m_data;

endmodule

// ----- src/mfu_checker.sv -----
// ----------------------------------------------------------------------------
// mfu_checker
// Port-level checks of the page replacement block, bound to the top level.
// ----------------------------------------------------------------------------
module mfu_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  logic [mfu_pkg::PAGE_FW-1:0]      i_s_tdata,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [mfu_pkg::OUT_W-1:0]        o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [mfu_pkg::CFG_W-1:0]        i_cfg_wdata
);

    // no result left over from before reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // the count write-back of an item comes before the next item is accepted
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted in back-to-back cycles");

    // a hit never evicts
    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[4]))
        else $error("hit and replaced both set");

    // evicted page reads zero without an eviction
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[4] |-> o_m_tdata[12:5] == 8'd0)
        else $error("evicted page set without eviction");

endmodule

bind mfu_page_replacement mfu_checker u_mfu_checker (.*);
